// ===== design/gbt_pkg.sv =====
// gbt_pkg: shared types and constants for the GEMM bias/transpose unit.
// No dependencies.
`default_nettype none
package gbt_pkg;

  localparam int OUT_W    = 40;   // Q16.24 result width
  localparam int RES_CAP  = 16;   // max results per compute item

  typedef enum logic [1:0] {
    REQ_LOAD_A    = 2'd0,
    REQ_LOAD_B    = 2'd1,
    REQ_LOAD_BIAS = 2'd2,
    REQ_COMPUTE   = 2'd3
  } req_t;

  localparam logic [2:0] CFG_TRANS_A   = 3'd0;
  localparam logic [2:0] CFG_TRANS_B   = 3'd1;
  localparam logic [2:0] CFG_OUT_ROWS  = 3'd2;
  localparam logic [2:0] CFG_OUT_COLS  = 3'd3;
  localparam logic [2:0] CFG_INNER_LEN = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COMP  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  // control handed to the accumulator ring
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [OUT_W-1:0] addend;
  } ring_ctl_t;

endpackage
`default_nettype wire

// ===== design/gbt_cell.sv =====
// gbt_cell: one accumulator cell of the ring.
// Depends on gbt_pkg.
`default_nettype none
module gbt_cell import gbt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic             load,
  input  wire logic [OUT_W-1:0] addend,
  input  wire logic [OUT_W-1:0] nbr,
  output logic      [OUT_W-1:0] acc
);

  always_ff @(posedge clk) begin
    if (shift) begin
      acc <= load ? addend : nbr + addend;
    end
  end

endmodule
`default_nettype wire

// ===== design/gbt_ring.sv =====
// gbt_ring: chain of accumulator cells; the tail folds the head back in.
// Depends on gbt_pkg and gbt_cell.
`default_nettype none
module gbt_ring import gbt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire ring_ctl_t        ctl,
  output logic      [OUT_W-1:0] head
);

  logic [OUT_W-1:0] acc [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      gbt_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .load   (ctl.load),
        .addend (ctl.addend),
        .nbr    (acc[0]),
        .acc    (acc[i])
      );
    end else begin : g_mid
      gbt_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .load   (1'b0),
        .addend ('0),
        .nbr    (acc[i+1]),
        .acc    (acc[i])
      );
    end
  end

  assign head = acc[0];

endmodule
`default_nettype wire

// ===== design/gemm_bias_transpose_unit.sv =====
// gemm_bias_transpose_unit: top level, stores, sequencer and output register.
// Depends on gbt_pkg and gbt_ring.
// Compute: every issue goes through one multiplier; after the pipeline drains,
// one result per cycle is given while out_ready.
// Synchronous active-high reset clears control and config; stores are not cleared.
`default_nettype none
module gemm_bias_transpose_unit import gbt_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // item channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             req_type,
  input  wire logic [3:0]             row_index,
  input  wire logic [3:0]             col_index,
  input  wire logic signed [ELEM_BITS-1:0] elem_value,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [OUT_W-1:0]     out_value,
  output logic [3:0]                  out_row,
  output logic [3:0]                  out_col,
  output logic                        last_in_row,
  // configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [4:0]             cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW     = $clog2(MAX_DIM + 2);
  localparam int DW     = (MAX_DIM > 30) ? $clog2(MAX_DIM + 1) : 5;
  localparam int NCAP   = (MAX_DIM < RES_CAP) ? MAX_DIM : RES_CAP;
  localparam int FRAC   = ELEM_BITS - 4;
  localparam int PROD_W = 2 * ELEM_BITS;

  // configuration
  logic       trans_a, trans_b;
  logic [4:0] out_rows, out_cols, inner_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_a   <= 1'b0;
      trans_b   <= 1'b0;
      out_rows  <= 5'd16;
      out_cols  <= 5'd16;
      inner_len <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRANS_A:   trans_a   <= cfg_data[0];
        CFG_TRANS_B:   trans_b   <= cfg_data[0];
        CFG_OUT_ROWS:  out_rows  <= cfg_data;
        CFG_OUT_COLS:  out_cols  <= cfg_data;
        CFG_INNER_LEN: inner_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [DW-1:0] m_c, n_c;
  logic [PW-1:0] k_c;
  assign m_c = (32'(out_rows) > MAX_DIM) ? DW'(MAX_DIM) : DW'(out_rows);
  assign n_c = (32'(out_cols) > NCAP) ? DW'(NCAP) : DW'(out_cols);
  assign k_c = (32'(inner_len) > MAX_DIM) ? PW'(MAX_DIM) : PW'(inner_len);

  state_t state;
  logic   in_xfer, out_xfer;
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // load decode
  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  assign ld_ok   = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign ld_addr = AW'(32'(row_index) * MAX_DIM + 32'(col_index));

  // stores
  logic [ELEM_BITS-1:0] a_mem    [DEPTH];
  logic [ELEM_BITS-1:0] b_mem    [DEPTH];
  logic [ELEM_BITS-1:0] bias_mem [MAX_DIM];

  // sequencer
  logic [3:0]    row_q;
  logic [JW-1:0] iss_j;
  logic [PW-1:0] iss_p;
  logic [DW-1:0] dj;
  logic          iss_last;
  logic [AW-1:0] a_addr, b_addr;
  int            kidx;

  assign iss_last = (iss_j == JW'(MAX_DIM - 1)) && (iss_p == k_c);

  always_comb begin
    kidx   = (iss_p == '0) ? 0 : 32'(iss_p) - 1;
    a_addr = trans_a ? AW'(kidx * MAX_DIM + 32'(row_q))
                     : AW'(32'(row_q) * MAX_DIM + kidx);
    b_addr = trans_b ? AW'(32'(iss_j) * MAX_DIM + kidx)
                     : AW'(kidx * MAX_DIM + 32'(iss_j));
  end

  // write ports
  always_ff @(posedge clk) begin
    if (in_xfer && ld_ok && req_type == REQ_LOAD_A) begin
      a_mem[ld_addr] <= elem_value;
    end
    if (in_xfer && ld_ok && req_type == REQ_LOAD_B) begin
      b_mem[ld_addr] <= elem_value;
    end
    if (in_xfer && 32'(col_index) < MAX_DIM && req_type == REQ_LOAD_BIAS) begin
      bias_mem[JW'(col_index)] <= elem_value;
    end
  end

  // stage 1: registered reads
  logic                 rd_valid, rd_bias;
  logic [ELEM_BITS-1:0] a_rd, b_rd, bias_rd;

  always_ff @(posedge clk) begin
    a_rd    <= a_mem[a_addr];
    b_rd    <= b_mem[b_addr];
    bias_rd <= bias_mem[iss_j];
  end

  // stage 2: multiply
  logic                     mul_valid, mul_bias;
  logic signed [PROD_W-1:0] prod;
  logic [ELEM_BITS-1:0]     bias_q;

  always_ff @(posedge clk) begin
    prod   <= signed'(a_rd) * signed'(b_rd);
    bias_q <= bias_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_bias   <= 1'b0;
      mul_valid <= 1'b0;
      mul_bias  <= 1'b0;
    end else begin
      rd_valid  <= (state == ST_COMP);
      rd_bias   <= (iss_p == '0);
      mul_valid <= rd_valid;
      mul_bias  <= rd_bias;
    end
  end

  // stage 3: accumulate in the ring; bias pass loads, later passes add; drain rotates results out
  logic signed [63:0] prod_x, bias_x;
  ring_ctl_t          ctl;
  logic [OUT_W-1:0]   head;
  logic               drain_go;

  assign drain_go = (state == ST_DRAIN) && (dj != n_c) && (!out_valid || out_ready);
  assign prod_x   = 64'(prod);
  assign bias_x   = 64'(signed'(bias_q)) <<< FRAC;

  always_comb begin
    ctl.shift  = mul_valid || drain_go;
    ctl.load   = mul_valid && mul_bias;
    ctl.addend = '0;
    if (mul_valid) begin
      ctl.addend = mul_bias ? bias_x[OUT_W-1:0] : prod_x[OUT_W-1:0];
    end
  end

  gbt_ring #(.DEPTH(MAX_DIM)) u_ring (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iss_j <= '0;
      iss_p <= '0;
      dj    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && req_type == REQ_COMPUTE &&
              32'(row_index) < 32'(m_c) && n_c != '0) begin
            state <= ST_COMP;
            iss_j <= '0;
            iss_p <= '0;
          end
        end
        ST_COMP: begin
          if (iss_last) begin
            state <= ST_WAIT;
          end else if (iss_j == JW'(MAX_DIM - 1)) begin
            iss_j <= '0;
            iss_p <= iss_p + 1'b1;
          end else begin
            iss_j <= iss_j + 1'b1;
          end
        end
        ST_WAIT: begin
          if (!rd_valid && !mul_valid) begin
            state <= ST_DRAIN;
            dj    <= '0;
          end
        end
        ST_DRAIN: begin
          if (dj == n_c) begin
            state <= ST_IDLE;
          end else if (drain_go) begin
            dj <= dj + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row_q <= row_index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_go) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_go) begin
      out_value   <= head;
      out_row     <= row_q;
      out_col     <= dj[3:0];
      last_in_row <= (dj == n_c - 1'b1);
    end
  end

endmodule
`default_nettype wire

// ===== design/gbt_checker.sv =====
// gbt_checker: port-level assertions for gemm_bias_transpose_unit, with bind.
// Depends on gbt_pkg.
`default_nettype none
module gbt_checker import gbt_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] out_value,
  input wire logic             last_in_row
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a row still in flight blocks new items
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_in_row |=> !in_ready)
    else $error("input accepted mid row");

endmodule

bind gemm_bias_transpose_unit gbt_checker u_gbt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_value   (out_value),
  .last_in_row (last_in_row)
);
`default_nettype wire
